/* rtl/svpwm_pkg.sv */
package svpwm_pkg;

    // Configuration register indexes.
    localparam int CFG_ADDR_W = 1;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD  = 1'b0;
    localparam logic [CFG_ADDR_W-1:0] CFG_MAX_MOD = 1'b1;

    // Register reset values.
    localparam logic [15:0] PERIOD_RESET  = 16'd4000;
    localparam logic [14:0] MAX_MOD_RESET = 15'd26214;

    // Q15 constants of the space vector geometry.
    localparam logic signed [17:0] K_ONE          = 18'sd32768;
    localparam logic signed [17:0] K_INV_SQRT3    = 18'sd18919;
    localparam logic signed [17:0] K_TWO_BY_SQRT3 = 18'sd37837;
    localparam logic [14:0]        K_SQRT3_BY_2   = 15'd28378;

    // Sine/cosine rotator: Q2.30 gain and arctangents in 2^32 units per turn.
    localparam int CORDIC_STEPS = 16;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;
    localparam logic signed [31:0] CORDIC_ATAN [CORDIC_STEPS] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458908, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861
    };

    // Per sextant: phase order (lowest count first) and the two on-time forms.
    typedef struct packed {
        logic [1:0]        ord0;
        logic [1:0]        ord1;
        logic [1:0]        ord2;
        logic signed [17:0] k1a;
        logic signed [17:0] k1b;
        logic signed [17:0] k2a;
        logic signed [17:0] k2b;
    } t_sext_row;

    function automatic t_sext_row sext_row(input logic [2:0] sx);
        t_sext_row row;
        case (sx)
            3'd1: row = '{2'd0, 2'd1, 2'd2, K_ONE, -K_INV_SQRT3, 18'sd0, K_TWO_BY_SQRT3};
            3'd2: row = '{2'd1, 2'd0, 2'd2, -K_ONE, K_INV_SQRT3, K_ONE, K_INV_SQRT3};
            3'd3: row = '{2'd1, 2'd2, 2'd0, 18'sd0, K_TWO_BY_SQRT3, -K_ONE, -K_INV_SQRT3};
            3'd4: row = '{2'd2, 2'd1, 2'd0, 18'sd0, -K_TWO_BY_SQRT3, -K_ONE, K_INV_SQRT3};
            3'd5: row = '{2'd2, 2'd0, 2'd1, -K_ONE, -K_INV_SQRT3, K_ONE, -K_INV_SQRT3};
            3'd6: row = '{2'd0, 2'd2, 2'd1, K_ONE, K_INV_SQRT3, 18'sd0, -K_TWO_BY_SQRT3};
            default: row = '{2'd0, 2'd1, 2'd2, K_ONE, -K_INV_SQRT3, 18'sd0, K_TWO_BY_SQRT3};
        endcase
        return row;
    endfunction

endpackage

/* rtl/svpwm_div.sv */
// Pipelined restoring divider: one quotient bit per stage, QW stages.
// The caller keeps i_num below i_den shifted up by QW bits.
module svpwm_div #(
    parameter int NW = 30,
    parameter int DW = 16,
    parameter int QW = 16
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic [QW-1:0] o_quo
);

    localparam int W = NW + DW + QW;

    logic [NW-1:0] r_rem [QW];
    logic [QW-1:0] r_quo [QW];
    logic [DW-1:0] r_den [QW];

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [NW-1:0] rem_in;
        logic [QW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [W-1:0]  sub;
        logic          fits;

        if (k == 0) begin : g_first
            assign rem_in = i_num;
            assign quo_in = '0;
            assign den_in = i_den;
        end else begin : g_next
            assign rem_in = r_rem[k-1];
            assign quo_in = r_quo[k-1];
            assign den_in = r_den[k-1];
        end

        // Trial subtraction of the divisor at this bit weight.
        // A zero divisor never fits, so its quotient stays zero.
        assign sub  = W'(den_in) << (QW - 1 - k);
        assign fits = (den_in != '0) && (W'(rem_in) >= sub);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= fits ? NW'(W'(rem_in) - sub) : rem_in;
                r_quo[k] <= fits ? (quo_in | (QW'(1) << (QW - 1 - k))) : quo_in;
                r_den[k] <= den_in;
            end
        end
    end

    assign o_quo = r_quo[QW-1];

endmodule

/* rtl/space_vector_pwm_modulator.sv */
// Channel   Direction  Handshake                         Payload
// s_axis    in         i_s_axis_tvalid / o_s_axis_tready  i_s_axis_tdata (64 bit)
// m_axis    out        o_m_axis_tvalid / i_m_axis_tready  o_m_axis_tdata (88 bit)
// cfg       in         i_cfg_we                           i_cfg_addr, i_cfg_wdata
//
// One item enters per cycle unless a result waits untaken at the output.
// The pipeline depth is set by the two bit-per-stage divider pairs and the square root stages.
// Reset (synchronous, active low) empties the pipeline and restores both registers.
// When a result waits at the output, every stage holds; nothing is dropped or repeated.
module space_vector_pwm_modulator #(
    parameter int ANGLE_BITS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // volt_d[15:0], volt_q[31:16], bus_voltage[47:32], rotor_angle[63:48]
    input  logic [63:0]                      i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // duty_a[15:0], duty_b[31:16], duty_c[47:32], mod_index_d[63:48],
    // mod_index_q[79:64], sextant[82:80], zeros above
    output logic [87:0]                      o_m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [svpwm_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [15:0]                      i_cfg_wdata
);

    import svpwm_pkg::*;

    localparam int NST      = 63;
    localparam int ISQ      = 17;
    localparam int LIM_QW   = 14;
    localparam int ANG_DROP = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
    localparam logic [15:0] ANG_MASK = 16'hFFFF << ANG_DROP;
    localparam int MDQ_DLY  = 43;

    typedef struct packed {
        logic sgn_d;
        logic ovf_d;
        logic sgn_q;
        logic ovf_q;
    } t_norm_side;

    typedef struct packed {
        logic signed [17:0] a;
        logic signed [17:0] b;
        logic               over;
    } t_lim_side;

    typedef struct packed {
        logic              sa;
        logic              sb;
        logic              over;
        logic signed [14:0] a;
        logic signed [14:0] b;
    } t_div_side;

    logic en;
    logic [NST-1:0] r_vld;

    // Configuration registers and the derived limit radius.
    logic [15:0] r_period;
    logic [14:0] r_max_mod;
    logic [13:0] r_radius;
    logic [27:0] r_r2;
    logic [29:0] rad_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= PERIOD_RESET;
            r_max_mod <= MAX_MOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_PERIOD:  r_period  <= i_cfg_wdata;
                CFG_MAX_MOD: r_max_mod <= i_cfg_wdata[14:0];
                default: ;
            endcase
        end
    end

    assign rad_prod = r_max_mod * K_SQRT3_BY_2;

    always_ff @(posedge i_clk) begin
        r_radius <= rad_prod[29:16];
        r_r2     <= r_radius * r_radius;
    end

    // Global stall: all stages move unless the output holds an untaken result.
    assign en              = !r_vld[NST-1] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[NST-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-2:0], i_s_axis_tvalid};
        end
    end

    // Stage 0: input register.
    logic signed [15:0] r_vd, r_vq;
    logic [15:0] r_bus, r_ang;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vd  <= i_s_axis_tdata[15:0];
            r_vq  <= i_s_axis_tdata[31:16];
            r_bus <= i_s_axis_tdata[47:32];
            r_ang <= i_s_axis_tdata[63:48];
        end
    end

    // Stage 1: dividend |v|*24576, overflow test, rotator start values.
    logic [15:0] mag_d, mag_q;
    logic [16:0] mag3_d, mag3_q;
    logic [29:0] num_d, num_q;
    logic [15:0] pa, pa_plus, rem16;
    logic [1:0]  quad0;
    logic [29:0] r_num_d, r_num_q;
    logic [15:0] r_bus1;

    assign mag_d  = r_vd[15] ? 16'(-r_vd) : r_vd;
    assign mag_q  = r_vq[15] ? 16'(-r_vq) : r_vq;
    assign mag3_d = {1'b0, mag_d} + {mag_d, 1'b0};
    assign mag3_q = {1'b0, mag_q} + {mag_q, 1'b0};
    assign num_d  = {mag3_d, 13'b0};
    assign num_q  = {mag3_q, 13'b0};

    assign pa      = r_ang & ANG_MASK;
    assign pa_plus = pa + 16'h2000;
    assign quad0   = pa_plus[15:14];
    assign rem16   = pa - {quad0, 14'b0};

    t_norm_side r_nside [CORDIC_STEPS+1];
    logic signed [32:0] r_cx [CORDIC_STEPS+1];
    logic signed [32:0] r_cy [CORDIC_STEPS+1];
    logic signed [31:0] r_cz [CORDIC_STEPS+1];
    logic [1:0]         r_cq [CORDIC_STEPS+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_d  <= num_d;
            r_num_q  <= num_q;
            r_bus1   <= r_bus;
            r_nside[0] <= '{sgn_d: r_vd[15],
                            ovf_d: (mag_d != 16'd0) && ({2'b0, num_d} >= {r_bus, 16'b0}),
                            sgn_q: r_vq[15],
                            ovf_q: (mag_q != 16'd0) && ({2'b0, num_q} >= {r_bus, 16'b0})};
            r_cx[0] <= CORDIC_GAIN;
            r_cy[0] <= '0;
            r_cz[0] <= {rem16, 16'b0};
            r_cq[0] <= quad0;
        end
    end

    // Stages 2..17: normalizing dividers and the rotator, one step per stage.
    logic [15:0] quo_d, quo_q;

    svpwm_div #(.NW(30), .DW(16), .QW(16)) u_div_d (
        .i_clk (i_clk), .i_en (en), .i_num (r_num_d), .i_den (r_bus1), .o_quo (quo_d)
    );

    svpwm_div #(.NW(30), .DW(16), .QW(16)) u_div_q (
        .i_clk (i_clk), .i_en (en), .i_num (r_num_q), .i_den (r_bus1), .o_quo (quo_q)
    );

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        logic signed [32:0] dx, dy;
        logic               pos;
        assign dx  = r_cy[i] >>> i;
        assign dy  = r_cx[i] >>> i;
        assign pos = !r_cz[i][31];
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_cx[i+1]    <= pos ? r_cx[i] - dx : r_cx[i] + dx;
                r_cy[i+1]    <= pos ? r_cy[i] + dy : r_cy[i] - dy;
                r_cz[i+1]    <= pos ? r_cz[i] - CORDIC_ATAN[i] : r_cz[i] + CORDIC_ATAN[i];
                r_cq[i+1]    <= r_cq[i];
                r_nside[i+1] <= r_nside[i];
            end
        end
    end

    // Stage 18: saturated modulation indices, Q2.14 sine and cosine.
    function automatic logic signed [15:0] norm_sat(input logic [15:0] q, input logic sgn,
                                                    input logic ovf);
        logic signed [15:0] res;
        if (ovf || q[15]) begin
            res = sgn ? 16'sh8000 : 16'sh7FFF;
        end else begin
            res = sgn ? -$signed(q) : $signed(q);
        end
        return res;
    endfunction

    function automatic logic signed [15:0] to_q14(input logic signed [32:0] v);
        logic signed [33:0] t;
        logic signed [17:0] r;
        t = {v[32], v} + 34'sd32768;
        r = t[33:16];
        if (r > 18'sd16384) begin
            r = 18'sd16384;
        end else if (r < -18'sd16384) begin
            r = -18'sd16384;
        end
        return r[15:0];
    endfunction

    logic signed [15:0] xq, yq, n_sin, n_cos;
    logic signed [15:0] r_md, r_mq, r_sin, r_cos;

    assign xq = to_q14(r_cx[CORDIC_STEPS]);
    assign yq = to_q14(r_cy[CORDIC_STEPS]);

    always_comb begin
        case (r_cq[CORDIC_STEPS])
            2'd0: begin n_cos = xq;  n_sin = yq;  end
            2'd1: begin n_cos = -yq; n_sin = xq;  end
            2'd2: begin n_cos = -xq; n_sin = -yq; end
            default: begin n_cos = yq; n_sin = -xq; end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_md  <= norm_sat(quo_d, r_nside[CORDIC_STEPS].sgn_d, r_nside[CORDIC_STEPS].ovf_d);
            r_mq  <= norm_sat(quo_q, r_nside[CORDIC_STEPS].sgn_q, r_nside[CORDIC_STEPS].ovf_q);
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    // Stage 19: inverse Park products.
    logic signed [31:0] r_pcm, r_psq, r_psm, r_pcq;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_pcm <= r_cos * r_md;
            r_psq <= r_sin * r_mq;
            r_psm <= r_sin * r_md;
            r_pcq <= r_cos * r_mq;
        end
    end

    // Stage 20: alpha and beta, floored to Q4.14.
    logic signed [32:0] da, db;
    logic signed [17:0] r_a20, r_b20;

    assign da = {r_pcm[31], r_pcm} - {r_psq[31], r_psq};
    assign db = {r_psm[31], r_psm} + {r_pcq[31], r_pcq};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a20 <= da[31:14];
            r_b20 <= db[31:14];
        end
    end

    // Stage 21: squares; stage 22: magnitude squared against the limit.
    logic signed [35:0] a_sq, b_sq;
    logic [32:0] r_a2, r_b2;
    logic signed [17:0] r_a21, r_b21;
    logic [33:0] mag2;

    assign a_sq = r_a20 * r_a20;
    assign b_sq = r_b20 * r_b20;
    assign mag2 = {1'b0, r_a2} + {1'b0, r_b2};

    logic [34:0] r_sv [ISQ+1];
    logic [34:0] r_sr [ISQ+1];
    t_lim_side   r_lside [ISQ+1];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a2    <= a_sq[32:0];
            r_b2    <= b_sq[32:0];
            r_a21   <= r_a20;
            r_b21   <= r_b20;
            r_sv[0] <= {1'b0, mag2};
            r_sr[0] <= '0;
            r_lside[0] <= '{a: r_a21, b: r_b21, over: mag2 > {6'b0, r_r2}};
        end
    end

    // Stages 23..39: integer square root, one result bit per stage.
    for (genvar k = 0; k < ISQ; k++) begin : g_isqrt
        logic [34:0] bitv, trial;
        logic        take;
        assign bitv  = 35'(1) << (2 * (ISQ - 1 - k));
        assign trial = r_sr[k] + bitv;
        assign take  = r_sv[k] >= trial;
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sv[k+1]    <= take ? r_sv[k] - trial : r_sv[k];
                r_sr[k+1]    <= take ? (r_sr[k] >> 1) + bitv : r_sr[k] >> 1;
                r_lside[k+1] <= r_lside[k];
            end
        end
    end

    // Stage 40: scaled magnitudes |x|*r for the limiting divide.
    logic [16:0] abs_a, abs_b;
    logic [30:0] r_num_a, r_num_b;
    logic [17:0] r_m;
    t_div_side   r_dside [LIM_QW+1];

    assign abs_a = r_lside[ISQ].a[17] ? 17'(-r_lside[ISQ].a) : r_lside[ISQ].a[16:0];
    assign abs_b = r_lside[ISQ].b[17] ? 17'(-r_lside[ISQ].b) : r_lside[ISQ].b[16:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num_a <= abs_a * r_radius;
            r_num_b <= abs_b * r_radius;
            r_m     <= r_sr[ISQ][17:0];
            r_dside[0] <= '{sa: r_lside[ISQ].a[17], sb: r_lside[ISQ].b[17],
                            over: r_lside[ISQ].over,
                            a: r_lside[ISQ].a[14:0], b: r_lside[ISQ].b[14:0]};
        end
    end

    // Stages 41..54: limiting divide by the magnitude.
    logic [LIM_QW-1:0] quo_a, quo_b;

    svpwm_div #(.NW(31), .DW(18), .QW(LIM_QW)) u_div_a (
        .i_clk (i_clk), .i_en (en), .i_num (r_num_a), .i_den (r_m), .o_quo (quo_a)
    );

    svpwm_div #(.NW(31), .DW(18), .QW(LIM_QW)) u_div_b (
        .i_clk (i_clk), .i_en (en), .i_num (r_num_b), .i_den (r_m), .o_quo (quo_b)
    );

    for (genvar k = 0; k < LIM_QW; k++) begin : g_dside
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_dside[k+1] <= r_dside[k];
            end
        end
    end

    // Stage 55: limited alpha and beta.
    logic signed [14:0] qa, qb;
    logic signed [14:0] r_al, r_bl;

    assign qa = r_dside[LIM_QW].sa ? -$signed({1'b0, quo_a}) : $signed({1'b0, quo_a});
    assign qb = r_dside[LIM_QW].sb ? -$signed({1'b0, quo_b}) : $signed({1'b0, quo_b});

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_al <= r_dside[LIM_QW].over ? qa : r_dside[LIM_QW].a;
            r_bl <= r_dside[LIM_QW].over ? qb : r_dside[LIM_QW].b;
        end
    end

    // Stage 56: 3*alpha^2 and beta^2 for the sector boundaries.
    logic signed [29:0] al_sq, bl_sq;
    logic [30:0] r_a3;
    logic [28:0] r_bsq;
    logic signed [14:0] r_al56, r_bl56;

    assign al_sq = r_al * r_al;
    assign bl_sq = r_bl * r_bl;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a3   <= {2'b0, al_sq[28:0]} + {1'b0, al_sq[28:0], 1'b0};
            r_bsq  <= bl_sq[28:0];
            r_al56 <= r_al;
            r_bl56 <= r_bl;
        end
    end

    // Stage 57: sextant.
    logic [2:0] n_sx;
    logic [2:0] r_sx [6];
    logic signed [14:0] r_al57, r_bl57;

    always_comb begin
        if (!r_bl56[14]) begin
            if (!r_al56[14]) n_sx = ({2'b0, r_bsq} > r_a3) ? 3'd2 : 3'd1;
            else             n_sx = ({2'b0, r_bsq} < r_a3) ? 3'd3 : 3'd2;
        end else begin
            if (!r_al56[14]) n_sx = ({2'b0, r_bsq} > r_a3) ? 3'd5 : 3'd6;
            else             n_sx = ({2'b0, r_bsq} < r_a3) ? 3'd4 : 3'd5;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sx[0] <= n_sx;
            r_al57  <= r_al56;
            r_bl57  <= r_bl56;
        end
    end

    for (genvar k = 0; k < 5; k++) begin : g_sxdly
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sx[k+1] <= r_sx[k];
            end
        end
    end

    // Stage 58: on-time products from the sextant row.
    t_sext_row row;
    logic signed [32:0] r_p1a, r_p1b, r_p2a, r_p2b;
    logic [5:0] r_ord [4];

    assign row = sext_row(r_sx[0]);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p1a    <= row.k1a * r_al57;
            r_p1b    <= row.k1b * r_bl57;
            r_p2a    <= row.k2a * r_al57;
            r_p2b    <= row.k2b * r_bl57;
            r_ord[0] <= {row.ord2, row.ord1, row.ord0};
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_orddly
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_ord[k+1] <= r_ord[k];
            end
        end
    end

    // Stage 59: Q29 on-times, negative ones taken as zero.
    logic signed [33:0] v1, v2;
    logic [29:0] r_v1, r_v2;

    assign v1 = {r_p1a[32], r_p1a} + {r_p1b[32], r_p1b};
    assign v2 = {r_p2a[32], r_p2a} + {r_p2b[32], r_p2b};

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_v1 <= v1[33] ? '0 : v1[29:0];
            r_v2 <= v2[33] ? '0 : v2[29:0];
        end
    end

    // Stage 60: scale by the period.
    logic [45:0] t1_full, t2_full;
    logic [16:0] r_t1, r_t2;

    assign t1_full = r_v1 * r_period;
    assign t2_full = r_v2 * r_period;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1 <= t1_full[45:29];
            r_t2 <= t2_full[45:29];
        end
    end

    // Stage 61: keep both on-times within the period.
    logic [15:0] t1c, left;
    logic [15:0] r_t1c, r_t2c;

    assign t1c  = (r_t1 > {1'b0, r_period}) ? r_period : r_t1[15:0];
    assign left = r_period - t1c;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_t1c <= t1c;
            r_t2c <= (r_t2 > {1'b0, left}) ? left : r_t2[15:0];
        end
    end

    // Stage 62: centre-aligned compare counts, output register.
    logic [15:0] zero_t, cnt_mid, cnt_hi;
    logic [15:0] n_cnt [3];
    logic [15:0] r_cnt [3];
    logic [31:0] r_mdq [MDQ_DLY+1];

    assign zero_t  = (r_period - r_t1c - r_t2c) >> 1;
    assign cnt_mid = zero_t + r_t1c;
    assign cnt_hi  = zero_t + r_t1c + r_t2c;

    always_comb begin
        for (int p = 0; p < 3; p++) begin
            if (r_ord[3][1:0] == 2'(p)) begin
                n_cnt[p] = zero_t;
            end else if (r_ord[3][3:2] == 2'(p)) begin
                n_cnt[p] = cnt_mid;
            end else begin
                n_cnt[p] = cnt_hi;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cnt[0] <= n_cnt[0];
            r_cnt[1] <= n_cnt[1];
            r_cnt[2] <= n_cnt[2];
            r_mdq[0] <= {r_mq, r_md};
        end
    end

    // Modulation indices ride alongside from stage 18 to the output.
    for (genvar k = 0; k < MDQ_DLY; k++) begin : g_mdqdly
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_mdq[k+1] <= r_mdq[k];
            end
        end
    end

    assign o_m_axis_tdata = {5'b0, r_sx[5], r_mdq[MDQ_DLY], r_cnt[2], r_cnt[1], r_cnt[0]};

    // Checks.
    a_duty_le_period: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_cnt[0] <= r_period && r_cnt[1] <= r_period
                             && r_cnt[2] <= r_period))
        else $error("compare count exceeds the PWM period");

    a_sextant_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_sx[5] >= 3'd1 && r_sx[5] <= 3'd6))
        else $error("sextant out of range");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> r_vld == $past(r_vld))
        else $error("pipeline moved during a stall");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_limit_radius: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[55] |-> ((r_al[14] ? 15'(-r_al) : r_al) <= {1'b0, r_radius}))
        else $error("limited alpha beyond radius");

endmodule
